// ----- rtl/assert_macros.svh -----
// Assertion macros for the slot pool manager.
// Clocked on aclk, disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lspm_pkg.sv -----
// Package for the linked slot pool manager.
// Opcodes, status codes, FSM states and request/result structs; no dependencies.
`timescale 1ns / 1ps

package lspm_pkg;

    localparam int POOL_SIZE_DEF = 32;
    localparam int OP_W          = 2;
    localparam int ID_W          = 5;
    localparam int STAT_W        = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_LIST  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_NOT_ACTIVE = 2'd2,
        STAT_EMPTY      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE_WALK,
        S_FREE_FIN,
        S_LIST,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic [ID_W-1:0] target_id;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   result_id;
        logic              last;
    } out_item_t;

endpackage

// ----- rtl/lspm_link_mem.sv -----
// Next-pointer store: one write port, one registered read port.
// Per-entry written bits give the reset chain (entry i -> i+1). Uses lspm_pkg.
`timescale 1ns / 1ps

module lspm_link_mem import lspm_pkg::*; #(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [$clog2(POOL_SIZE)-1:0]    rd_addr,
    output logic [$clog2(POOL_SIZE+1)-1:0]  rd_data,
    input  logic                            wr_en,
    input  logic [$clog2(POOL_SIZE)-1:0]    wr_addr,
    input  logic [$clog2(POOL_SIZE+1)-1:0]  wr_data
);

    localparam int PW = $clog2(POOL_SIZE + 1);
    localparam int IW = $clog2(POOL_SIZE);

    logic [PW-1:0]        mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] written_reg;
    logic [PW-1:0]        mem_q_reg;
    logic [IW-1:0]        addr_q_reg;
    logic                 written_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg  <= mem[rd_addr];
        addr_q_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg   <= '0;
            written_q_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            written_q_reg <= written_reg[rd_addr];
        end
    end

    assign rd_data = written_q_reg ? mem_q_reg
                                   : PW'({1'b0, addr_q_reg} + (IW+1)'(1));

endmodule

// ----- rtl/lspm_ctrl.sv -----
// Sequencer for allocate, free and list requests over the link store.
// Holds both list heads; walks one link per cycle, a list walk holding while the result side is full. Uses lspm_pkg.
`timescale 1ns / 1ps

module lspm_ctrl import lspm_pkg::*; #(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  in_item_t                        s_item,
    input  logic                            out_free,
    output logic                            res_valid,
    output out_item_t                       res_item,
    output logic [$clog2(POOL_SIZE)-1:0]    mem_rd_addr,
    input  logic [$clog2(POOL_SIZE+1)-1:0]  mem_rd_data,
    output logic                            mem_wr_en,
    output logic [$clog2(POOL_SIZE)-1:0]    mem_wr_addr,
    output logic [$clog2(POOL_SIZE+1)-1:0]  mem_wr_data
);

    localparam int PW    = $clog2(POOL_SIZE + 1);
    localparam int IW    = $clog2(POOL_SIZE);
    localparam int CW    = $clog2(POOL_SIZE);
    localparam int CMP_W = (PW > ID_W) ? PW : ID_W;
    localparam logic [PW-1:0] NULL_PTR = PW'(POOL_SIZE);
    localparam logic [CW-1:0] CNT_LAST = CW'(POOL_SIZE - 1);

    state_t            state_reg, state_next;
    logic [PW-1:0]     active_head_reg, active_head_next;
    logic [PW-1:0]     free_head_reg, free_head_next;
    logic [PW-1:0]     cur_reg, cur_next;
    logic [PW-1:0]     prev_reg, prev_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [ID_W-1:0]   target_reg, target_next;
    status_t           status_reg, status_next;

    logic [CMP_W-1:0]  cur_ext;
    logic [CMP_W-1:0]  tgt_ext;
    logic [CMP_W-1:0]  in_tgt_ext;
    logic              rd_null;
    logic              list_fin;

    assign cur_ext    = CMP_W'(cur_reg);
    assign tgt_ext    = CMP_W'(target_reg);
    assign in_tgt_ext = CMP_W'(s_item.target_id);
    assign rd_null    = (mem_rd_data >= NULL_PTR);
    assign list_fin   = rd_null || (cnt_reg == CNT_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            active_head_reg <= NULL_PTR;
            free_head_reg   <= '0;
        end else begin
            state_reg       <= state_next;
            active_head_reg <= active_head_next;
            free_head_reg   <= free_head_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        cnt_reg    <= cnt_next;
        target_reg <= target_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next       = state_reg;
        active_head_next = active_head_reg;
        free_head_next   = free_head_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        cnt_next         = cnt_reg;
        target_next      = target_reg;
        status_next      = status_reg;
        s_ready          = (state_reg == S_IDLE);
        res_valid        = 1'b0;
        res_item         = '0;
        mem_rd_addr      = cur_reg[IW-1:0];
        mem_wr_en        = 1'b0;
        mem_wr_addr      = cur_reg[IW-1:0];
        mem_wr_data      = free_head_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    target_next = s_item.target_id;
                    unique case (opcode_t'(s_item.opcode))
                        OP_ALLOC: begin
                            if (free_head_reg >= NULL_PTR) begin
                                status_next = STAT_FULL;
                                state_next  = S_EMIT;
                            end else begin
                                cur_next    = free_head_reg;
                                mem_rd_addr = free_head_reg[IW-1:0];
                                state_next  = S_ALLOC;
                            end
                        end
                        OP_FREE: begin
                            if (active_head_reg >= NULL_PTR ||
                                in_tgt_ext >= CMP_W'(POOL_SIZE)) begin
                                status_next = STAT_NOT_ACTIVE;
                                state_next  = S_EMIT;
                            end else begin
                                cur_next    = active_head_reg;
                                prev_next   = NULL_PTR;
                                cnt_next    = '0;
                                mem_rd_addr = active_head_reg[IW-1:0];
                                state_next  = S_FREE_WALK;
                            end
                        end
                        OP_LIST: begin
                            if (active_head_reg >= NULL_PTR) begin
                                status_next = STAT_EMPTY;
                                state_next  = S_EMIT;
                            end else begin
                                cur_next    = active_head_reg;
                                cnt_next    = '0;
                                mem_rd_addr = active_head_reg[IW-1:0];
                                state_next  = S_LIST;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (out_free) begin
                    mem_wr_en          = 1'b1;
                    mem_wr_data        = active_head_reg;
                    free_head_next     = mem_rd_data;
                    active_head_next   = cur_reg;
                    res_valid          = 1'b1;
                    res_item.status    = STAT_OK;
                    res_item.result_id = cur_ext[ID_W-1:0];
                    res_item.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_FREE_WALK: begin
                if (cur_ext == tgt_ext) begin
                    if (prev_reg >= NULL_PTR) begin
                        active_head_next = mem_rd_data;
                    end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = prev_reg[IW-1:0];
                        mem_wr_data = mem_rd_data;
                    end
                    state_next = S_FREE_FIN;
                end else if (list_fin) begin
                    status_next = STAT_NOT_ACTIVE;
                    state_next  = S_EMIT;
                end else begin
                    prev_next   = cur_reg;
                    cur_next    = mem_rd_data;
                    cnt_next    = cnt_reg + CW'(1);
                    mem_rd_addr = mem_rd_data[IW-1:0];
                end
            end
            S_FREE_FIN: begin
                if (out_free) begin
                    mem_wr_en          = 1'b1;
                    free_head_next     = cur_reg;
                    res_valid          = 1'b1;
                    res_item.status    = STAT_OK;
                    res_item.result_id = cur_ext[ID_W-1:0];
                    res_item.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    res_valid          = 1'b1;
                    res_item.status    = STAT_OK;
                    res_item.result_id = cur_ext[ID_W-1:0];
                    res_item.last      = list_fin;
                    if (list_fin) begin
                        state_next = S_IDLE;
                    end else begin
                        cur_next    = mem_rd_data;
                        cnt_next    = cnt_reg + CW'(1);
                        mem_rd_addr = mem_rd_data[IW-1:0];
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    res_valid       = 1'b1;
                    res_item.status = status_reg;
                    res_item.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/linked_slot_pool_manager_core.sv -----
// Top level of the linked slot pool manager: controller, link store, result register.
// Depends on lspm_pkg, lspm_ctrl, lspm_link_mem and assert_macros.svh.
//
// Usage:
//   s_valid/s_ready/s_item carry requests: allocate, free by id, or list.
//   m_valid/m_ready/m_item carry results: status, slot id and a last flag.
//   Allocate and free give one result; list gives one result per active
//   slot, newest first, or a single empty result. Opcode 3 gives none.
// Timing:
//   One request at a time. Allocate reads the free head, then relinks
//   the slot; free walks the active list to the id, then unlinks it;
//   list gives a result per link walked. Walks are paced by the single
//   read port of the link store, one link per cycle, a list walk holding
//   while the result register is full. Results leave through a register,
//   so the next request is taken while the final result still waits on
//   m_ready. A stalled receiver halts a list walk; nothing is dropped.
// Reset:
//   aresetn low for one edge puts every slot on the free list in order and
//   empties the active list; no clearing pass, requests accepted at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linked_slot_pool_manager_core import lspm_pkg::*; #(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int PW = $clog2(POOL_SIZE + 1);
    localparam int IW = $clog2(POOL_SIZE);

    logic          out_free;
    logic          res_valid;
    out_item_t     res_item;
    logic [IW-1:0] mem_rd_addr;
    logic [PW-1:0] mem_rd_data;
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    logic [PW-1:0] mem_wr_data;
    logic          m_valid_reg;
    out_item_t     m_item_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    lspm_ctrl #(
        .POOL_SIZE (POOL_SIZE)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res_item    (res_item),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    lspm_link_mem #(
        .POOL_SIZE (POOL_SIZE)
    ) u_link_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_item_reg <= res_item;
        end
    end

    `ASSERT_IMP(a_no_overwrite, res_valid, (!m_valid_reg || m_ready), "result register overwritten")
    `ASSERT_IMP(a_err_shape, (m_valid && m_item.status != STAT_OK), (m_item.result_id == ID_W'(0) && m_item.last), "error result not single with zero id")
    `ASSERT_NXT(a_busy_after_req, (s_valid && s_ready && s_item.opcode != OP_NONE), !s_ready, "request accepted while a request is still in work")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for linked_slot_pool_manager_core.
// Tracks the free and active lists on every request and checks each result in order.
// Depends on lspm_pkg and the RTL of the pool manager.
`timescale 1ns / 1ps

module tb_top;
    import lspm_pkg::*;

    localparam int POOL       = POOL_SIZE_DEF;
    localparam int NULL_SLOT  = POOL;
    localparam int RAND_ITEMS = 400;
    localparam int LIMIT      = 400000;

    class slot_pool_tracker;
        int            next_link [POOL];
        int            active_head;
        int            free_head;
        out_item_t     expected_results [$];
        int unsigned   errors;

        function new();
            for (int i = 0; i < POOL; i++) begin
                next_link[i] = i + 1;
            end
            active_head = NULL_SLOT;
            free_head   = 0;
            errors      = 0;
        endfunction

        function void queue_result(status_t st, int id, logic fin);
            out_item_t r;
            r.status    = st;
            r.result_id = ID_W'(id);
            r.last      = fin;
            expected_results.push_back(r);
        endfunction

        function void note_request(in_item_t req);
            int slot;
            int prev;
            int cur;
            int steps;
            int nxt;
            case (req.opcode)
                OP_ALLOC: begin
                    if (free_head >= POOL) begin
                        queue_result(STAT_FULL, 0, 1'b1);
                    end else begin
                        slot = free_head;
                        free_head = next_link[slot];
                        next_link[slot] = active_head;
                        active_head = slot;
                        queue_result(STAT_OK, slot, 1'b1);
                    end
                end
                OP_FREE: begin
                    prev  = NULL_SLOT;
                    cur   = active_head;
                    steps = 0;
                    while (cur < POOL && steps < POOL) begin
                        if (cur == int'(req.target_id)) begin
                            if (prev < POOL) begin
                                next_link[prev] = next_link[cur];
                            end else begin
                                active_head = next_link[cur];
                            end
                            next_link[cur] = free_head;
                            free_head = cur;
                            queue_result(STAT_OK, cur, 1'b1);
                            return;
                        end
                        prev = cur;
                        cur  = next_link[cur];
                        steps++;
                    end
                    queue_result(STAT_NOT_ACTIVE, 0, 1'b1);
                end
                OP_LIST: begin
                    cur = active_head;
                    if (cur >= POOL) begin
                        queue_result(STAT_EMPTY, 0, 1'b1);
                    end else begin
                        steps = 0;
                        while (cur < POOL && steps < POOL) begin
                            nxt = next_link[cur];
                            queue_result(STAT_OK, cur, (nxt >= POOL) || (steps + 1 >= POOL));
                            steps++;
                            cur = nxt;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with none pending: status %0d id %0d last %0d",
                         $time, got.status, got.result_id, got.last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.result_id !== want.result_id) begin
                $display("%0t: result_id expected %0d actual %0d",
                         $time, want.result_id, got.result_id);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d actual %0d",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // random id from the active list, or any id when it is empty
        function int pick_active_id();
            int ids [$];
            int cur;
            cur = active_head;
            while (cur < POOL && ids.size() < POOL) begin
                ids.push_back(cur);
                cur = next_link[cur];
            end
            if (ids.size() == 0) begin
                return $urandom_range(0, POOL - 1);
            end
            return ids[$urandom_range(0, ids.size() - 1)];
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    slot_pool_tracker tracker;
    int unsigned      cycle_count = 0;
    int               burst_left  = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    linked_slot_pool_manager_core #(.POOL_SIZE(POOL)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready) begin
                tracker.note_request(s_item);
            end
            if (m_valid && m_ready) begin
                tracker.check_result(m_item);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: ready runs of random length broken by short stalls
    initial begin
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            m_ready <= 1'b1;
            repeat (($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12)) @(negedge aclk);
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    end

    // entered and left at a falling edge; bursts with random gaps
    task automatic issue(opcode_t op, int id);
        in_item_t req;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req.opcode    = op;
        req.target_id = id[ID_W-1:0];
        s_item  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        int n;
        int r;
        int phase;
        int waited;
        tracker = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty pool, unused opcode, head and middle frees, repeats
        issue(OP_LIST, 0);
        issue(OP_FREE, 0);
        issue(OP_FREE, 31);
        issue(OP_NONE, 31);
        issue(OP_ALLOC, 31);
        issue(OP_ALLOC, 0);
        issue(OP_ALLOC, 21);
        issue(OP_LIST, 31);
        issue(OP_FREE, 1);
        issue(OP_FREE, 1);
        issue(OP_FREE, 2);
        issue(OP_FREE, 0);
        issue(OP_LIST, 0);
        issue(OP_ALLOC, 0);
        issue(OP_FREE, 31);
        issue(OP_LIST, 10);
        issue(OP_FREE, 0);
        issue(OP_NONE, 0);

        // random: fill, fill, mix, drain, drain, mix ... so the pool fills and empties
        n = 0;
        while (n < RAND_ITEMS) begin
            case ((n / 40) % 6)
                0, 1:    phase = 0;
                3, 4:    phase = 1;
                default: phase = 2;
            endcase
            r = $urandom_range(0, 99);
            if (phase == 0) begin
                r = (r < 70) ? 0 : (r < 85) ? 1 : (r < 92) ? 2 : (r < 99) ? 3 : 4;
            end else if (phase == 1) begin
                r = (r < 20) ? 0 : (r < 70) ? 1 : (r < 82) ? 2 : (r < 97) ? 3 : 4;
            end else begin
                r = (r < 40) ? 0 : (r < 65) ? 1 : (r < 80) ? 2 : (r < 97) ? 3 : 4;
            end
            case (r)
                0: issue(OP_ALLOC, $urandom_range(0, 31));
                1: issue(OP_FREE, tracker.pick_active_id());
                2: issue(OP_FREE, $urandom_range(0, 31));
                3: issue(OP_LIST, $urandom_range(0, 31));
                default: issue(OP_NONE, $urandom_range(0, 31));
            endcase
            if (r != 4) begin
                n++;
            end
        end
        s_valid <= 1'b0;

        while (tracker.pending() != 0) begin
            @(posedge aclk);
        end
        waited = 0;
        while (waited < 2 * POOL + 8) begin
            @(posedge aclk);
            waited++;
        end
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- linked_slot_pool_manager_core.f -----
+incdir+rtl
rtl/lspm_pkg.sv
rtl/lspm_link_mem.sv
rtl/lspm_ctrl.sv
rtl/linked_slot_pool_manager_core.sv
tb/tb_top.sv
